// ===== src/edu_pkg.sv =====
// Shared types and constants of the Euclidean distance unit.
`default_nettype none
package edu_pkg;

    localparam int ELEM_W     = 16;
    localparam int DIFF_W     = ELEM_W + 1;
    localparam int SQ_W       = 2 * ELEM_W;
    localparam int SUM_W      = 48;
    localparam int DIST_W     = SUM_W / 2;
    localparam int REM_W      = DIST_W + 2;
    localparam int ROOT_STEPS = DIST_W;
    localparam int CNT_W      = $clog2(ROOT_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_DONE
    } edu_state_t;

    typedef struct packed {
        logic s1_load;
        logic s1_advance;
        logic root_load;
        logic root_step;
    } edu_cmd_t;

    typedef struct packed {
        logic sq_valid;
        logic sq_last;
    } edu_sts_t;

endpackage
`default_nettype wire

// ===== src/euclidean_distance_unit.sv =====
// Top level of the Euclidean distance unit: controller, datapath and checks.
//
// Usage: element pairs of two vectors enter on the input channel (elem_a, elem_b,
// last under in_valid/in_ready), one item per cycle. Each pair's squared
// difference is added to a 48-bit accumulator that saturates at its maximum.
// The item flagged last closes the vector: the sum goes to a square-root unit
// and the accumulator clears, so the next vector may stream in at once.
// The distance (unsigned Q24.0, floor of the root) appears on the output
// channel (distance under out_valid/out_ready) after the last item has passed
// the square stage and the root unit. The root unit retires one result bit
// per cycle, 24 bits in all, and handles one vector at a time; a new
// vector's items keep flowing while it runs, and only the next last item
// waits until it is free again. Sustained rate: one item per cycle for
// vectors of 26 or more pairs while each result is taken at once.
// A stalled receiver holds the result in place; the block then keeps taking
// items until a further last item is ready to leave the square stage.
// Reset clears the accumulator and all handshake state; no result is pending.
`default_nettype none
module euclidean_distance_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [edu_pkg::ELEM_W-1:0] elem_a,
    input  wire logic signed [edu_pkg::ELEM_W-1:0] elem_b,
    input  wire logic                              last,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [edu_pkg::DIST_W-1:0]             distance
);
    import edu_pkg::*;

    edu_cmd_t cmd;
    edu_sts_t sts;

    edu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    edu_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .elem_a   (elem_a),
        .elem_b   (elem_b),
        .last     (last),
        .cmd      (cmd),
        .sts      (sts),
        .distance (distance)
    );

    // The input only stalls behind a closing item waiting for the root unit.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (sts.sq_valid && sts.sq_last))
        else $error("input stalled without a pending closing item");

    // A root load never starts while a result is still on offer or the root unit is still stepping.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.root_load |-> !out_valid && !cmd.root_step)
        else $error("square root loaded while busy");

    // A result appears only right after the final root step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.root_step))
        else $error("result offered without a finished square root");

endmodule
`default_nettype wire

// ===== src/edu_ctrl.sv =====
// Controller of the Euclidean distance unit: handshakes and square-root sequencing.
`default_nettype none
module edu_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire edu_pkg::edu_sts_t sts,
    output edu_pkg::edu_cmd_t     cmd
);
    import edu_pkg::*;

    edu_state_t        state_reg;
    edu_state_t        state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              root_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (cmd.root_load)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        root_free      = (state_reg == ST_IDLE);
        cmd.s1_advance = sts.sq_valid && (!sts.sq_last || root_free);
        cmd.root_load  = cmd.s1_advance && sts.sq_last;
        cmd.root_step  = (state_reg == ST_ROOT);
        in_ready       = !sts.sq_valid || cmd.s1_advance;
        cmd.s1_load    = in_valid && in_ready;
        out_valid      = (state_reg == ST_DONE);
    end

endmodule
`default_nettype wire

// ===== src/edu_dp.sv =====
// Datapath of the Euclidean distance unit: square, saturating sum and square root.
`default_nettype none
module edu_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic signed [edu_pkg::ELEM_W-1:0] elem_a,
    input  wire logic signed [edu_pkg::ELEM_W-1:0] elem_b,
    input  wire logic                              last,
    input  wire edu_pkg::edu_cmd_t                 cmd,
    output edu_pkg::edu_sts_t                      sts,
    output logic [edu_pkg::DIST_W-1:0]             distance
);
    import edu_pkg::*;

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        diff_abs;
    logic [ELEM_W-1:0]        mag;
    logic [SQ_W-1:0]          sq_next;
    logic [SQ_W-1:0]          sq_reg;
    logic                     sq_valid_reg;
    logic                     sq_last_reg;
    logic [SUM_W:0]           sum_wide;
    logic [SUM_W-1:0]         sum_sat;
    logic [SUM_W-1:0]         acc_reg;
    logic [SUM_W-1:0]         rad_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [DIST_W-1:0]        root_reg;
    logic [REM_W+1:0]         rem_trial;
    logic [REM_W+1:0]         sub_val;
    logic                     fits;

    // Square of the difference; magnitude fits 16 bits unsigned.
    always_comb
    begin
        diff     = DIFF_W'(elem_a) - DIFF_W'(elem_b);
        diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        mag      = diff_abs[ELEM_W-1:0];
        sq_next  = mag * mag;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.s1_load)
        begin
            sq_reg      <= sq_next;
            sq_last_reg <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else if (cmd.s1_load)
        begin
            sq_valid_reg <= 1'b1;
        end
        else if (cmd.s1_advance)
        begin
            sq_valid_reg <= 1'b0;
        end
    end

    assign sts.sq_valid = sq_valid_reg;
    assign sts.sq_last  = sq_last_reg;

    // Saturating accumulation.
    always_comb
    begin
        sum_wide = {1'b0, acc_reg} + (SUM_W + 1)'(sq_reg);
        sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (cmd.s1_advance)
        begin
            acc_reg <= sq_last_reg ? '0 : sum_sat;
        end
    end

    // Restoring square root, one result bit per step.
    always_comb
    begin
        rem_trial = {rem_reg, rad_reg[SUM_W-1 -: 2]};
        sub_val   = (REM_W + 2)'({root_reg, 2'b01});
        fits      = (rem_trial >= sub_val);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.root_load)
        begin
            rad_reg  <= sum_sat;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[SUM_W-3:0], 2'b00};
            rem_reg  <= fits ? REM_W'(rem_trial - sub_val) : REM_W'(rem_trial);
            root_reg <= {root_reg[DIST_W-2:0], fits};
        end
    end

    assign distance = root_reg;

endmodule
`default_nettype wire
